/* rtl/imu_dr_pkg.sv */
package imu_dr_pkg;

    localparam int WIN_LEN = 14;
    localparam int LANES   = 3;
    localparam int QDEPTH  = 2;

    localparam logic [7:0] LEN_BYTE = 8'h0C;

    // configuration register indexes
    localparam logic [1:0] CFG_DT    = 2'd0;
    localparam logic [1:0] CFG_GROUP = 2'd1;
    localparam logic [1:0] CFG_TYPE  = 2'd2;

    localparam logic [15:0] DT_RESET    = 16'd1638;
    localparam logic [7:0]  GROUP_RESET = 8'h40;
    localparam logic [7:0]  TYPE_RESET  = 8'h30;

    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] EXP_UNIT     = 8'd134;  // exponent where man maps 1:1 onto Q16.16
    localparam logic [7:0] EXP_SAT      = 8'd142;
    localparam logic [7:0] EXP_FLUSH    = 8'd110;

    typedef struct packed {
        logic                   match;
        logic                   last;
        logic [LANES-1:0][31:0] words;
    } cmd_t;

    typedef struct packed {
        logic [LANES-1:0][31:0] accel;
        logic [LANES-1:0][31:0] vel;
        logic [LANES-1:0][31:0] pos;
        logic [7:0]             samples;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VCONV,
        S_VMUL,
        S_VADD,
        S_PMUL,
        S_PADD,
        S_EMIT
    } back_state_t;

    typedef struct packed {
        logic       emit;
        logic [1:0] lane;
    } back_status_t;

    // IEEE single to Q16.16, truncating, saturating, NaN to zero
    function automatic logic [31:0] f2q(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [7:0]  shl;
        logic [7:0]  shr;
        logic [31:0] mag;
        logic [31:0] res;
        neg = bits[31];
        ex  = bits[30:23];
        man = bits[22:0];
        shl = ex - EXP_UNIT;
        shr = EXP_UNIT - ex;
        mag = 32'd0;
        if (ex >= EXP_UNIT)
            mag = {8'd0, 1'b1, man} << shl[2:0];
        else if (ex > EXP_FLUSH)
            mag = {8'd0, 1'b1, man} >> shr[4:0];
        if ((ex == EXP_ALL_ONES && man != 23'd0) || ex == 8'd0)
            res = 32'd0;
        else if (ex >= EXP_SAT)
            res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            res = neg ? (32'd0 - mag) : mag;
        return res;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [31:0] res;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            res = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            res = s[31:0];
        return res;
    endfunction

endpackage

/* rtl/imu_dr_front.sv */
module imu_dr_front
    import imu_dr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_in_message,
    input  logic [7:0]  header_group,
    input  logic [7:0]  header_type,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    logic [7:0] win_reg [0:WIN_LEN-1];
    logic [3:0] seen_reg;
    logic       accept;
    logic       match;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    assign match = (seen_reg == 4'(WIN_LEN)) && (win_reg[0] == header_group) &&
                   (win_reg[1] == header_type) && (win_reg[2] == LEN_BYTE);

    // only requests that change back-end state go into the queue
    assign push_valid     = accept && (match || last_in_message);
    assign push_cmd.match = match;
    assign push_cmd.last  = last_in_message;
    assign push_cmd.words[0] = {win_reg[3], win_reg[4], win_reg[5], win_reg[6]};
    assign push_cmd.words[1] = {win_reg[7], win_reg[8], win_reg[9], win_reg[10]};
    assign push_cmd.words[2] = {win_reg[11], win_reg[12], win_reg[13], data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 4'd0;
            for (int i = 0; i < WIN_LEN; i++)
                win_reg[i] <= 8'd0;
        end
        else if (accept)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[WIN_LEN-1] <= data_byte;
            // a cleared count is enough: no match until the window refills
            if (last_in_message)
                seen_reg <= 4'd0;
            else if (seen_reg != 4'(WIN_LEN))
                seen_reg <= seen_reg + 4'd1;
        end
    end

endmodule

/* rtl/imu_dr_fifo.sv */
module imu_dr_fifo
    import imu_dr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output logic       head_valid,
    output cmd_t       head_cmd,
    output logic [1:0] count
);

    cmd_t       entry_reg [0:QDEPTH-1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'(QDEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* rtl/imu_dr_back.sv */
module imu_dr_back
    import imu_dr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [15:0]  dt_q16,
    input  logic         head_valid,
    input  cmd_t         head_cmd,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      result,
    output back_status_t status
);

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cmd_reg;
    logic [1:0]  lane_reg;
    logic [31:0] accel_reg [0:LANES-1];
    logic [31:0] vel_reg [0:LANES-1];
    logic [31:0] pos_reg [0:LANES-1];
    logic [7:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic        sign_reg;
    logic        out_valid_reg;
    result_t     result_reg;

    logic        emit;
    logic        last_lane;
    logic [31:0] mul_src;
    logic [31:0] mul_mag;
    logic [47:0] mul_full;
    logic [31:0] addend;

    assign last_lane = (lane_reg == 2'(LANES - 1));

    // shared 32x16 multiplier: |value| * dt, sign restored after the register
    assign mul_src  = (state_reg == S_PMUL) ? vel_reg[lane_reg] : accel_reg[lane_reg];
    assign mul_mag  = mul_src[31] ? (32'd0 - mul_src) : mul_src;
    assign mul_full = {16'd0, mul_mag} * {32'd0, dt_q16};
    assign addend   = sign_reg ? (32'd0 - prod_reg) : prod_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                    state_next = head_cmd.match ? S_VCONV : S_PMUL;
            end
            S_VCONV: state_next = S_VMUL;
            S_VMUL:  state_next = S_VADD;
            S_VADD:
            begin
                if (!last_lane)
                    state_next = S_VCONV;
                else
                    state_next = cmd_reg.last ? S_PMUL : S_IDLE;
            end
            S_PMUL:  state_next = S_PADD;
            S_PADD:  state_next = last_lane ? S_EMIT : S_PMUL;
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            S_IDLE:  pop  = head_valid;
            S_EMIT:  emit = !out_valid_reg || out_ready;
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= 2'd0;
            cnt_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                accel_reg[i] <= 32'd0;
                vel_reg[i]   <= 32'd0;
                pos_reg[i]   <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_VCONV: accel_reg[lane_reg] <= f2q(cmd_reg.words[lane_reg]);
                S_VADD:
                begin
                    vel_reg[lane_reg] <= sat_add(vel_reg[lane_reg], addend);
                    if (last_lane)
                    begin
                        lane_reg <= 2'd0;
                        if (cnt_reg != 8'hFF)
                            cnt_reg <= cnt_reg + 8'd1;
                    end
                    else
                        lane_reg <= lane_reg + 2'd1;
                end
                S_PADD:
                begin
                    pos_reg[lane_reg] <= sat_add(pos_reg[lane_reg], addend);
                    lane_reg <= last_lane ? 2'd0 : lane_reg + 2'd1;
                end
                S_EMIT:
                begin
                    if (emit)
                        cnt_reg <= 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head_cmd;
        if (state_reg == S_VMUL || state_reg == S_PMUL)
        begin
            prod_reg <= mul_full[47:16];
            sign_reg <= mul_src[31];
        end
        if (emit)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                result_reg.accel[i] <= accel_reg[i];
                result_reg.vel[i]   <= vel_reg[i];
                result_reg.pos[i]   <= pos_reg[i];
            end
            result_reg.samples <= cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign status.emit = emit;
    assign status.lane = lane_reg;

endmodule

/* rtl/imu_packet_dead_reckoning.sv */
// IMU acceleration-packet dead reckoning.
// Input: one message byte per request (data_byte, last_in_message) on
// in_valid/in_ready. Output: one request per message, on out_valid/out_ready,
// carrying acceleration, velocity and position (Q16.16) and the count of
// acceleration frames matched in that message.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while the block
// idles; the user must keep to this, the block does not enforce it. The front
// end takes one byte per cycle while its two-entry queue has room; only bytes
// that complete a frame or end a message enter the queue. Back end: pops a
// command when idle, then per frame converts, multiplies and adds for each of
// 3 axes, and per message end multiplies and adds position for each axis and
// loads the result, all on one shared 32x16 multiplier.
// The result stays in an output register; a stalled receiver holds it there
// while the back end keeps working and only waits before loading the next one.
// Reset clears the window, the counters and the stored accel, velocity and
// position values; the config registers return to dt 1638, header 0x40 0x30.
module imu_packet_dead_reckoning
    import imu_dr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_in_message,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [7:0]         samples_in_message,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0]  dt_reg;
    logic [7:0]   group_reg;
    logic [7:0]   type_reg;

    logic         push_valid;
    logic         push_ready;
    cmd_t         push_cmd;
    logic         pop;
    logic         head_valid;
    cmd_t         head_cmd;
    logic [1:0]   fifo_count;
    result_t      res;
    back_status_t bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg    <= DT_RESET;
            group_reg <= GROUP_RESET;
            type_reg  <= TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DT:    dt_reg    <= cfg_data;
                CFG_GROUP: group_reg <= cfg_data[7:0];
                CFG_TYPE:  type_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    imu_dr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .last_in_message (last_in_message),
        .header_group    (group_reg),
        .header_type     (type_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_cmd        (push_cmd)
    );

    imu_dr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (fifo_count)
    );

    imu_dr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dt_q16     (dt_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (res),
        .status     (bstat)
    );

    assign accel_x = $signed(res.accel[0]);
    assign accel_y = $signed(res.accel[1]);
    assign accel_z = $signed(res.accel[2]);
    assign vel_x   = $signed(res.vel[0]);
    assign vel_y   = $signed(res.vel[1]);
    assign vel_z   = $signed(res.vel[2]);
    assign pos_x   = $signed(res.pos[0]);
    assign pos_y   = $signed(res.pos[1]);
    assign pos_z   = $signed(res.pos[2]);
    assign samples_in_message = res.samples;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= 2'(QDEPTH))
        else $error("queue count beyond depth");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.emit |=> out_valid)
        else $error("result load without out_valid");

    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.lane <= 2'(LANES - 1))
        else $error("axis counter out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> fifo_count != 2'(QDEPTH))
        else $error("push into full queue");

endmodule
